// ===== rtl/core/mfd_pkg.sv =====
package mfd_pkg;

    localparam int KeyIdW      = 32;
    localparam int KeyPortW    = 16;
    localparam int BeatW       = 32;
    localparam int TimeW       = 32;
    localparam int TimeoutW    = 16;
    localparam int MaxRemovals = 32;
    localparam int RemCntW     = 6;

    typedef enum logic [1:0] {
        KIND_MERGE     = 2'd0,
        KIND_HEARTBEAT = 2'd1,
        KIND_TICK      = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_ADDED   = 2'd1,
        EV_REMOVED = 2'd2,
        EV_FULL    = 2'd3
    } t_evres;

    typedef enum logic [0:0] {
        CFG_FAIL_TIMEOUT   = 1'b0,
        CFG_REMOVE_TIMEOUT = 1'b1
    } t_cfg_idx;

    localparam logic [TimeoutW-1:0] FailTimeoutReset   = 16'd5;
    localparam logic [TimeoutW-1:0] RemoveTimeoutReset = 16'd20;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                valid;
        logic                failed;
        logic [KeyIdW-1:0]   key_id;
        logic [KeyPortW-1:0] key_port;
        logic [BeatW-1:0]    beat;
        logic [TimeW-1:0]    seen_time;
    } t_entry;

    typedef struct packed {
        logic [1:0]          kind;
        logic [KeyIdW-1:0]   peer_id;
        logic [KeyPortW-1:0] peer_port;
        logic [BeatW-1:0]    peer_heartbeat;
    } t_req;

    typedef struct packed {
        logic [TimeoutW-1:0] fail_timeout;
        logic [TimeoutW-1:0] remove_timeout;
    } t_cfg;

    typedef struct packed {
        logic                valid;
        logic [1:0]          res;
        logic [KeyIdW-1:0]   id;
        logic [KeyPortW-1:0] port;
        logic                last;
    } t_evt;

endpackage

// ===== rtl/core/membership_failure_detector_core.sv =====
// merge, heartbeat and tick requests each scan the whole peer table, one table read a
// cycle on its single read port, held while a removal waits on a stalled event output; no
// new request is taken until the last result is out; removals stream out one per cycle
// during a tick while the output is ready; reset: synchronous, active low; a clearing pass
// then runs over the table with s_axis_tready low, configuration writes are taken throughout
module membership_failure_detector_core import mfd_pkg::*; #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // peer_id, peer_port, peer_heartbeat
    input  logic [1:0]  s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // event_id, event_port
    output logic [1:0]  m_axis_tuser,  // event_res
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    logic [TimeoutW-1:0] r_fail_to;
    logic [TimeoutW-1:0] r_rem_to;
    logic                r_ovalid;
    logic [1:0]          r_ores;
    logic [KeyIdW-1:0]   r_oid;
    logic [KeyPortW-1:0] r_oport;
    logic                r_olast;

    t_req req;
    t_cfg cfg;
    t_evt evt;
    logic evt_ready;

    assign req.kind           = s_axis_tuser;
    assign req.peer_id        = s_axis_tdata[31:0];
    assign req.peer_port      = s_axis_tdata[47:32];
    assign req.peer_heartbeat = s_axis_tdata[79:48];

    assign cfg.fail_timeout   = r_fail_to;
    assign cfg.remove_timeout = r_rem_to;

    assign evt_ready = !r_ovalid || m_axis_tready;

    mfd_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req       (req),
        .o_req_ready (s_axis_tready),
        .i_cfg       (cfg),
        .o_evt       (evt),
        .i_evt_ready (evt_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_to <= FailTimeoutReset;
            r_rem_to  <= RemoveTimeoutReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_FAIL_TIMEOUT:   r_fail_to <= i_cfg_wdata;
                CFG_REMOVE_TIMEOUT: r_rem_to  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (evt_ready) begin
            r_ovalid <= evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (evt_ready && evt.valid) begin
            r_ores  <= evt.res;
            r_oid   <= evt.id;
            r_oport <= evt.port;
            r_olast <= evt.last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_oport, r_oid};
    assign m_axis_tuser  = r_ores;
    assign m_axis_tlast  = r_olast;

endmodule

// ===== rtl/core/mfd_ram.sv =====
module mfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/mfd_engine.sv =====
module mfd_engine import mfd_pkg::*; #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  t_req i_req,
    output logic o_req_ready,
    input  t_cfg i_cfg,
    output t_evt o_evt,
    input  logic i_evt_ready
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW:0]   Depth    = (AW+1)'(TABLE_ENTRIES);
    localparam logic [AW-1:0] LastAddr = AW'(TABLE_ENTRIES - 1);

    t_state               r_state, n_state;
    logic [AW-1:0]        r_clr, n_clr;
    logic [TimeW-1:0]     r_clock, n_clock;
    logic [1:0]           r_kind, n_kind;
    logic [KeyIdW-1:0]    r_id, n_id;
    logic [KeyPortW-1:0]  r_port, n_port;
    logic [BeatW-1:0]     r_beat, n_beat;
    logic [AW:0]          r_raddr, n_raddr;
    logic                 r_pv, n_pv;
    logic [AW-1:0]        r_paddr, n_paddr;
    logic                 r_hit, n_hit;
    logic [AW-1:0]        r_hit_addr, n_hit_addr;
    logic [BeatW-1:0]     r_hit_beat, n_hit_beat;
    logic                 r_hit_failed, n_hit_failed;
    logic                 r_free, n_free;
    logic [AW-1:0]        r_free_addr, n_free_addr;
    logic [RemCntW-1:0]   r_nrem, n_nrem;
    logic                 r_pend_v, n_pend_v;
    logic [KeyIdW-1:0]    r_pend_id, n_pend_id;
    logic [KeyPortW-1:0]  r_pend_port, n_pend_port;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    t_entry               ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    t_entry               ram_rdata;

    logic [TimeW-1:0]     silence;
    logic                 is_tick;
    logic                 match;
    logic                 fail_now;
    logic                 failed_new;
    logic                 rem_hit;
    logic                 stall;
    logic                 accept;
    t_entry               upd;

    mfd_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign is_tick    = (r_kind == KIND_TICK);
    assign silence    = r_clock - ram_rdata.seen_time;
    assign match      = ram_rdata.valid && (ram_rdata.key_id == r_id)
                        && (ram_rdata.key_port == r_port);
    assign fail_now   = ram_rdata.valid && !ram_rdata.failed
                        && (silence >= {16'd0, i_cfg.fail_timeout});
    assign failed_new = ram_rdata.failed || fail_now;
    assign rem_hit    = ram_rdata.valid && failed_new
                        && (silence >= {16'd0, i_cfg.remove_timeout})
                        && (r_nrem != RemCntW'(MaxRemovals));
    assign stall      = r_pv && is_tick && rem_hit && r_pend_v && !i_evt_ready;
    assign accept     = i_req_valid && o_req_ready;
    assign o_req_ready = (r_state == ST_IDLE);

    // refreshed or new entry for the input key
    always_comb begin
        upd           = '0;
        upd.valid     = 1'b1;
        upd.key_id    = r_id;
        upd.key_port  = r_port;
        upd.beat      = r_beat;
        upd.seen_time = r_clock;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == LastAddr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_req.kind == KIND_MERGE || i_req.kind == KIND_HEARTBEAT
                        || i_req.kind == KIND_TICK) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (!stall && r_raddr == Depth) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_evt_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_clr        = r_clr;
        n_clock      = r_clock;
        n_kind       = r_kind;
        n_id         = r_id;
        n_port       = r_port;
        n_beat       = r_beat;
        n_raddr      = r_raddr;
        n_pv         = r_pv;
        n_paddr      = r_paddr;
        n_hit        = r_hit;
        n_hit_addr   = r_hit_addr;
        n_hit_beat   = r_hit_beat;
        n_hit_failed = r_hit_failed;
        n_free       = r_free;
        n_free_addr  = r_free_addr;
        n_nrem       = r_nrem;
        n_pend_v     = r_pend_v;
        n_pend_id    = r_pend_id;
        n_pend_port  = r_pend_port;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        o_evt        = '0;

        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
            end
            ST_IDLE: begin
                if (accept) begin
                    n_kind   = i_req.kind;
                    n_id     = i_req.peer_id;
                    n_port   = i_req.peer_port;
                    n_beat   = i_req.peer_heartbeat;
                    n_raddr  = '0;
                    n_pv     = 1'b0;
                    n_hit    = 1'b0;
                    n_free   = 1'b0;
                    n_nrem   = '0;
                    n_pend_v = 1'b0;
                    if (i_req.kind == KIND_TICK) begin
                        n_clock = r_clock + 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    if (r_pv) begin
                        if (is_tick) begin
                            if (fail_now || rem_hit) begin
                                ram_we           = 1'b1;
                                ram_waddr        = r_paddr;
                                ram_wdata        = ram_rdata;
                                ram_wdata.failed = failed_new;
                                if (rem_hit) begin
                                    ram_wdata.valid  = 1'b0;
                                    ram_wdata.failed = 1'b0;
                                end
                            end
                            if (rem_hit) begin
                                if (r_pend_v) begin
                                    o_evt.valid = 1'b1;
                                    o_evt.res   = EV_REMOVED;
                                    o_evt.id    = r_pend_id;
                                    o_evt.port  = r_pend_port;
                                    o_evt.last  = 1'b0;
                                end
                                n_pend_v    = 1'b1;
                                n_pend_id   = ram_rdata.key_id;
                                n_pend_port = ram_rdata.key_port;
                                n_nrem      = r_nrem + 1'b1;
                            end
                        end else begin
                            if (match && !r_hit) begin
                                n_hit        = 1'b1;
                                n_hit_addr   = r_paddr;
                                n_hit_beat   = ram_rdata.beat;
                                n_hit_failed = ram_rdata.failed;
                            end
                            if (!ram_rdata.valid && !r_free) begin
                                n_free      = 1'b1;
                                n_free_addr = r_paddr;
                            end
                        end
                    end
                    ram_re    = (r_raddr < Depth);
                    ram_raddr = r_raddr[AW-1:0];
                    n_pv      = ram_re;
                    n_paddr   = r_raddr[AW-1:0];
                    if (ram_re) begin
                        n_raddr = r_raddr + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (i_evt_ready) begin
                    o_evt.valid = 1'b1;
                    o_evt.last  = 1'b1;
                    o_evt.res   = EV_NONE;
                    if (r_kind == KIND_MERGE) begin
                        o_evt.id   = r_id;
                        o_evt.port = r_port;
                        if (r_hit) begin
                            if (r_hit_beat < r_beat) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_hit_addr;
                                ram_wdata = upd;
                            end
                        end else if (r_free) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_free_addr;
                            ram_wdata = upd;
                            o_evt.res = EV_ADDED;
                        end else begin
                            o_evt.res = EV_FULL;
                        end
                    end else if (r_kind == KIND_HEARTBEAT) begin
                        o_evt.id   = r_id;
                        o_evt.port = r_port;
                        if (r_hit) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_hit_addr;
                            ram_wdata = r_hit_failed ? '0 : upd;
                        end
                    end else if (is_tick && r_pend_v) begin
                        o_evt.res  = EV_REMOVED;
                        o_evt.id   = r_pend_id;
                        o_evt.port = r_pend_port;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_clock <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_clock <= n_clock;
            r_pv    <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_id         <= n_id;
        r_port       <= n_port;
        r_beat       <= n_beat;
        r_raddr      <= n_raddr;
        r_paddr      <= n_paddr;
        r_hit        <= n_hit;
        r_hit_addr   <= n_hit_addr;
        r_hit_beat   <= n_hit_beat;
        r_hit_failed <= n_hit_failed;
        r_free       <= n_free;
        r_free_addr  <= n_free_addr;
        r_nrem       <= n_nrem;
        r_pend_v     <= n_pend_v;
        r_pend_id    <= n_pend_id;
        r_pend_port  <= n_pend_port;
    end

endmodule

// ===== tb/sv/tb_membership_failure_detector_core.sv =====
`timescale 1ns / 1ps

module tb_membership_failure_detector_core;
    import mfd_pkg::*;

    localparam int TableEntries = 32;
    localparam int ScanCycles = TableEntries + 3;
    localparam int KeyPool = 40;
    localparam int CycleLimit = 3000000;
    localparam logic [1:0] KindUnused = 2'd3;

    typedef struct {
        t_evres      res;
        logic [31:0] id;
        logic [15:0] port;
        logic        last;
    } t_peer_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;  // peer_id, peer_port, peer_heartbeat
    logic [1:0]  s_axis_tuser = '0;  // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;       // event_id, event_port
    logic [1:0]  m_axis_tuser;       // event_res
    logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_addr = '0;
    logic [15:0] i_cfg_wdata = '0;

    membership_failure_detector_core #(
        .TABLE_ENTRIES(TableEntries)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // shadow peer table
    logic        pt_valid  [TableEntries];
    logic        pt_failed [TableEntries];
    logic [31:0] pt_id     [TableEntries];
    logic [15:0] pt_port   [TableEntries];
    logic [31:0] pt_beat   [TableEntries];
    logic [31:0] pt_seen   [TableEntries];
    logic [31:0] peer_clock;
    logic [15:0] fail_ticks;
    logic [15:0] remove_ticks;

    logic [31:0] pool_id   [KeyPool];
    logic [15:0] pool_port [KeyPool];
    logic [31:0] pool_beat [KeyPool];

    t_req        request_queue[$];
    t_req        active_req;
    t_peer_event expected_events[$];
    int          error_count = 0;
    int          send_gap = 0;
    int          recv_stall = 0;
    int          cycle_count = 0;
    bit          gaps_on = 1'b1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void expect_event(input t_peer_event ev);
        expected_events = {expected_events, ev};
    endfunction

    task automatic update_peer_table(input t_req req);
        int          i;
        int          slot;
        int          free_slot;
        int          n;
        logic [31:0] silence;
        t_peer_event ev;
        t_peer_event held;
        slot = -1;
        free_slot = -1;
        n = 0;
        for (i = 0; i < TableEntries; i++) begin
            if (slot < 0 && pt_valid[i] && pt_id[i] == req.peer_id &&
                pt_port[i] == req.peer_port)
                slot = i;
            if (free_slot < 0 && !pt_valid[i])
                free_slot = i;
        end
        ev.res = EV_NONE;
        ev.id = req.peer_id;
        ev.port = req.peer_port;
        ev.last = 1'b1;
        case (req.kind)
            KIND_MERGE: begin
                if (slot >= 0) begin
                    if (pt_beat[slot] < req.peer_heartbeat) begin
                        pt_beat[slot] = req.peer_heartbeat;
                        pt_seen[slot] = peer_clock;
                        pt_failed[slot] = 1'b0;
                    end
                end else if (free_slot >= 0) begin
                    pt_valid[free_slot] = 1'b1;
                    pt_failed[free_slot] = 1'b0;
                    pt_id[free_slot] = req.peer_id;
                    pt_port[free_slot] = req.peer_port;
                    pt_beat[free_slot] = req.peer_heartbeat;
                    pt_seen[free_slot] = peer_clock;
                    ev.res = EV_ADDED;
                end else begin
                    ev.res = EV_FULL;
                end
                expect_event(ev);
            end
            KIND_HEARTBEAT: begin
                if (slot >= 0) begin
                    if (pt_failed[slot]) begin
                        pt_valid[slot] = 1'b0;
                        pt_failed[slot] = 1'b0;
                    end else begin
                        pt_beat[slot] = req.peer_heartbeat;
                        pt_seen[slot] = peer_clock;
                    end
                end
                expect_event(ev);
            end
            KIND_TICK: begin
                peer_clock = peer_clock + 32'd1;
                for (i = 0; i < TableEntries; i++) begin
                    silence = peer_clock - pt_seen[i];
                    if (pt_valid[i] && !pt_failed[i] && silence >= {16'd0, fail_ticks})
                        pt_failed[i] = 1'b1;
                end
                for (i = 0; i < TableEntries && n < MaxRemovals; i++) begin
                    silence = peer_clock - pt_seen[i];
                    if (pt_valid[i] && pt_failed[i] && silence >= {16'd0, remove_ticks}) begin
                        pt_valid[i] = 1'b0;
                        pt_failed[i] = 1'b0;
                        if (n > 0)
                            expect_event(held);
                        held.res = EV_REMOVED;
                        held.id = pt_id[i];
                        held.port = pt_port[i];
                        held.last = 1'b0;
                        n++;
                    end
                end
                if (n > 0) begin
                    held.last = 1'b1;
                    expect_event(held);
                end else begin
                    ev.id = '0;
                    ev.port = '0;
                    expect_event(ev);
                end
            end
            default: begin
                ev.id = '0;
                ev.port = '0;
                expect_event(ev);
            end
        endcase
    endtask

    task automatic check_event();
        t_peer_event exp_ev;
        if (expected_events.size() == 0) begin
            $error("unexpected event: event_res %0d event_id %h event_port %h",
                   m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[47:32]);
            error_count++;
        end else begin
            exp_ev = expected_events.pop_front();
            if (m_axis_tuser !== exp_ev.res) begin
                $error("event_res: expected %0d, got %0d", exp_ev.res, m_axis_tuser);
                error_count++;
            end
            if (m_axis_tdata[31:0] !== exp_ev.id) begin
                $error("event_id: expected %h, got %h", exp_ev.id, m_axis_tdata[31:0]);
                error_count++;
            end
            if (m_axis_tdata[47:32] !== exp_ev.port) begin
                $error("event_port: expected %h, got %h", exp_ev.port, m_axis_tdata[47:32]);
                error_count++;
            end
            if (m_axis_tlast !== exp_ev.last) begin
                $error("last: expected %0d, got %0d", exp_ev.last, m_axis_tlast);
                error_count++;
            end
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                update_peer_table(active_req);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (request_queue.size() != 0) begin
                    active_req = request_queue.pop_front();
                    s_axis_tdata <= {active_req.peer_heartbeat, active_req.peer_port,
                                     active_req.peer_id};
                    s_axis_tuser <= active_req.kind;
                    s_axis_tvalid <= 1'b1;
                    send_gap = idle_len();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // event monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_event();
            if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                recv_stall = idle_len();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void queue_request(input logic [1:0] kind, input logic [31:0] id,
                                          input logic [15:0] port, input logic [31:0] beat);
        t_req req;
        req.kind = kind;
        req.peer_id = id;
        req.peer_port = port;
        req.peer_heartbeat = beat;
        request_queue = {request_queue, req};
    endfunction

    function automatic void queue_random(input int tick_pct);
        int          r;
        int          k;
        int          pick;
        logic [31:0] beat;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, KeyPool - 1);
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            pool_beat[k] = pool_beat[k] + $urandom_range(1, 4);
            beat = pool_beat[k];
        end else if (pick < 9) begin
            beat = pool_beat[k] - $urandom_range(0, 2);
        end else begin
            beat = $urandom();
        end
        if (r < 4)
            queue_request(KindUnused, $urandom(), 16'($urandom_range(0, 65535)), $urandom());
        else if (r < 4 + tick_pct)
            queue_request(KIND_TICK, $urandom(), 16'($urandom_range(0, 65535)), $urandom());
        else if (r < 4 + tick_pct + (96 - tick_pct) * 55 / 100)
            queue_request(KIND_MERGE, pool_id[k], pool_port[k], beat);
        else if (r < 95)
            queue_request(KIND_HEARTBEAT, pool_id[k], pool_port[k], beat);
        else
            queue_request(KIND_HEARTBEAT, $urandom(), pool_port[k], beat);
    endfunction

    task automatic drain();
        while (request_queue.size() != 0 || s_axis_tvalid || expected_events.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        drain();
        repeat (ScanCycles) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        if (idx == CFG_FAIL_TIMEOUT)
            fail_ticks = value;
        else
            remove_ticks = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int i;
        int k;
        logic [15:0] ft;
        for (i = 0; i < TableEntries; i++) begin
            pt_valid[i] = 1'b0;
            pt_failed[i] = 1'b0;
        end
        peer_clock = '0;
        fail_ticks = FailTimeoutReset;
        remove_ticks = RemoveTimeoutReset;
        for (i = 0; i < KeyPool; i++) begin
            pool_id[i] = $urandom();
            pool_port[i] = 16'($urandom_range(0, 65535));
            pool_beat[i] = $urandom_range(0, 1000);
        end
        pool_id[0] = '0;
        pool_port[0] = '0;
        pool_id[1] = '1;
        pool_port[1] = '1;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset timeouts: add, refresh, unknown peer, unused kind, fail, drop, revive
        queue_request(KIND_MERGE, 32'h0, 16'h0, 32'h0);
        queue_request(KIND_MERGE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        queue_request(KIND_MERGE, 32'h0, 16'h0, 32'h0);
        queue_request(KIND_MERGE, 32'h0, 16'h0, 32'd5);
        queue_request(KIND_HEARTBEAT, 32'h0, 16'h0, 32'd3);
        queue_request(KIND_HEARTBEAT, 32'h1234_5678, 16'h9ABC, 32'd7);
        queue_request(KindUnused, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        for (i = 0; i < 5; i++)
            queue_request(KIND_TICK, 32'h0, 16'h0, 32'h0);
        queue_request(KIND_HEARTBEAT, 32'hFFFF_FFFF, 16'hFFFF, 32'h0);
        queue_request(KIND_MERGE, 32'h0, 16'h0, 32'd6);

        // zero timeouts
        write_reg(CFG_FAIL_TIMEOUT, 16'd0);
        write_reg(CFG_REMOVE_TIMEOUT, 16'd0);
        queue_request(KIND_MERGE, 32'hA5A5_5A5A, 16'h5A5A, 32'h1);
        queue_request(KIND_TICK, 32'h0, 16'h0, 32'h0);

        // largest timeouts
        write_reg(CFG_FAIL_TIMEOUT, 16'hFFFF);
        write_reg(CFG_REMOVE_TIMEOUT, 16'hFFFF);
        queue_request(KIND_MERGE, 32'h5A5A_A5A5, 16'hA5A5, 32'h10);
        queue_request(KIND_TICK, 32'h0, 16'h0, 32'h0);
        queue_request(KIND_TICK, 32'h0, 16'h0, 32'h0);
        queue_request(KIND_HEARTBEAT, 32'h5A5A_A5A5, 16'hA5A5, 32'h0);

        // random, short timeouts
        ft = 16'($urandom_range(1, 4));
        write_reg(CFG_FAIL_TIMEOUT, ft);
        write_reg(CFG_REMOVE_TIMEOUT, 16'(ft + $urandom_range(1, 6)));
        for (i = 0; i < 100; i++)
            queue_random(25);

        // fill the table past full, then mass removal
        write_reg(CFG_FAIL_TIMEOUT, 16'd1);
        write_reg(CFG_REMOVE_TIMEOUT, 16'd1);
        gaps_on = 1'b0;
        for (i = 0; i < 48; i++) begin
            k = $urandom_range(0, KeyPool - 1);
            pool_beat[k] = pool_beat[k] + 1;
            queue_request(KIND_MERGE, pool_id[k], pool_port[k], pool_beat[k]);
        end
        queue_request(KIND_TICK, $urandom(), 16'($urandom_range(0, 65535)), $urandom());
        for (i = 0; i < 20; i++)
            queue_random(30);
        drain();
        gaps_on = 1'b1;

        // peers fail but are never removed
        write_reg(CFG_FAIL_TIMEOUT, 16'd2);
        write_reg(CFG_REMOVE_TIMEOUT, 16'hFFFF);
        for (i = 0; i < 60; i++)
            queue_random(25);

        // nothing fails, failed peers go at once
        write_reg(CFG_FAIL_TIMEOUT, 16'hFFFF);
        write_reg(CFG_REMOVE_TIMEOUT, 16'd1);
        for (i = 0; i < 20; i++)
            queue_random(30);

        write_reg(CFG_FAIL_TIMEOUT, 16'd3);
        write_reg(CFG_REMOVE_TIMEOUT, 16'd8);
        for (i = 0; i < 80; i++)
            queue_random(20);

        drain();
        repeat (ScanCycles) @(posedge i_clk);
        if (error_count == 0 && expected_events.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
